// File: hdl/bsu_pkg.sv
// Shared types and constants for the bead sort unit.
`default_nettype none

package bsu_pkg;

  // Width of one value, fixed by the item format.
  localparam int VALUE_W = 4;

  // Highest bead level that a value of VALUE_W bits can reach.
  localparam int HW_LEVELS = (1 << VALUE_W) - 1;

  typedef logic [VALUE_W-1:0] value_t;

  // Commands from the sequencer to the level counter bank.
  typedef struct packed {
    logic   inc;    // count the beads of value into the levels
    logic   clear;  // return all level counts to zero
    value_t value;  // value of the item being loaded
  } level_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/bsu_if.sv
// Valid/ready channel interfaces for the input items and the sorted results.
`default_nettype none

interface bsu_in_if;
  logic            valid;
  logic            ready;
  bsu_pkg::value_t value;
  logic            last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface bsu_out_if;
  logic            valid;
  logic            ready;
  bsu_pkg::value_t sorted_value;
  logic            last_result;

  modport source (output valid, output sorted_value, output last_result, input ready);
  modport sink   (input valid, input sorted_value, input last_result, output ready);
endinterface

`default_nettype wire

// File: hdl/bead_sort_unit.sv
// Top level of the bead sort unit: level counter bank and its sequencer.
//
//   channel   direction  payload                      marks
//   items     in         value[3:0], last_item        last_item ends the set
//   results   out        sorted_value[3:0], last_result  last_result on final value
//
// Each item is loaded while the sequencer is in its load state; the counter bank
// adds its beads to all levels at once. A set of n items is emitted as n results,
// while the shared compare climbs at most min(MAX_VALUE, 15) levels between
// them. The item that fills the store of MAX_ITEMS closes the set. Reset is
// synchronous and clears the counts at once. A stalled result holds back the
// next result, though the pointer may still climb; items are refused while a set is emitted.
`default_nettype none

module bead_sort_unit #(
  parameter int MAX_ITEMS = 64,
  parameter int MAX_VALUE = 15
) (
  input  wire logic clk,
  input  wire logic rst,
  bsu_in_if.sink    items,
  bsu_out_if.source results
);

  // Levels above what a value can reach never fill and are left out.
  localparam int NUM_LEVELS = (MAX_VALUE < bsu_pkg::HW_LEVELS) ? MAX_VALUE
                                                                : bsu_pkg::HW_LEVELS;
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
  localparam int PTR_W      = $clog2(NUM_LEVELS + 1);

  bsu_pkg::level_ctrl_t ctrl;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     rd_count;

  bsu_seq #(
    .MAX_ITEMS  (MAX_ITEMS),
    .NUM_LEVELS (NUM_LEVELS),
    .CNT_W      (CNT_W),
    .PTR_W      (PTR_W)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .items    (items),
    .results  (results),
    .ctrl     (ctrl),
    .rd_ptr   (rd_ptr),
    .rd_count (rd_count)
  );

  bsu_levels #(
    .NUM_LEVELS (NUM_LEVELS),
    .CNT_W      (CNT_W),
    .PTR_W      (PTR_W)
  ) u_levels (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .rd_ptr   (rd_ptr),
    .rd_count (rd_count)
  );

endmodule

`default_nettype wire

// File: hdl/bsu_levels.sv
// Bank of bead level counters with one read port.
`default_nettype none

module bsu_levels #(
  parameter int NUM_LEVELS = 15,
  parameter int CNT_W      = 7,
  parameter int PTR_W      = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire bsu_pkg::level_ctrl_t ctrl,
  input  wire logic [PTR_W-1:0]     rd_ptr,
  output logic [CNT_W-1:0]          rd_count
);

  logic [CNT_W-1:0] counts [NUM_LEVELS];

  // Each level counts the items whose value lies above it. Values above the
  // top level simply fill every level, which saturates them.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        counts[l] <= '0;
      end
    end else if (ctrl.inc) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        if (ctrl.value > bsu_pkg::value_t'(l)) begin
          counts[l] <= counts[l] + CNT_W'(1);
        end
      end
    end
  end

  // Read port; a pointer past the top level reads as an empty level.
  always_comb begin
    rd_count = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (rd_ptr == PTR_W'(l)) begin
        rd_count = counts[l];
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/bsu_seq.sv
// Load and emit sequencer with the shared level compare and the result register.
`default_nettype none

module bsu_seq #(
  parameter int MAX_ITEMS  = 64,
  parameter int NUM_LEVELS = 15,
  parameter int CNT_W      = 7,
  parameter int PTR_W      = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  bsu_in_if.sink                     items,
  bsu_out_if.source                  results,
  output bsu_pkg::level_ctrl_t       ctrl,
  output logic [PTR_W-1:0]           rd_ptr,
  input  wire logic [CNT_W-1:0]      rd_count
);

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic             state;
  logic [CNT_W-1:0] item_count;
  logic [CNT_W-1:0] need;
  logic [PTR_W-1:0] ptr;
  logic             out_valid;
  bsu_pkg::value_t  out_value;
  logic             out_last;

  logic             accept_in;
  logic [CNT_W-1:0] count_inc;
  logic             end_set;
  logic             level_hit;
  logic             out_free;
  logic             emit;

  assign items.ready          = (state == ST_LOAD);
  assign accept_in            = items.valid && items.ready;
  assign count_inc            = item_count + CNT_W'(1);
  assign end_set              = items.last_item || (count_inc == CNT_W'(MAX_ITEMS));

  // Shared compare: a level whose count reaches the number still needed holds
  // a bead of the current result, so the pointer climbs past it.
  assign level_hit = (ptr != PTR_W'(NUM_LEVELS)) && (rd_count >= need);
  assign out_free  = !out_valid || results.ready;
  assign emit      = (state == ST_EMIT) && !level_hit && out_free;

  assign rd_ptr     = ptr;
  assign ctrl.inc   = accept_in;
  assign ctrl.value = items.value;
  assign ctrl.clear = emit && (need == CNT_W'(1));

  assign results.valid        = out_valid;
  assign results.sorted_value = out_value;
  assign results.last_result  = out_last;

  // Sequencer: count items in, then walk the levels once per set.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      item_count <= '0;
      need       <= '0;
      ptr        <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (accept_in) begin
            if (end_set) begin
              state      <= ST_EMIT;
              need       <= count_inc;
              ptr        <= '0;
              item_count <= '0;
            end else begin
              item_count <= count_inc;
            end
          end
        end
        ST_EMIT: begin
          if (level_hit) begin
            ptr <= ptr + PTR_W'(1);
          end else if (emit) begin
            need <= need - CNT_W'(1);
            if (need == CNT_W'(1)) begin
              state <= ST_LOAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Result register; it holds a result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value <= bsu_pkg::value_t'(ptr);
      out_last  <= (need == CNT_W'(1));
    end
  end

  // The set never grows to the store size without being closed.
  a_count_below_max: assert property (@(posedge clk) disable iff (rst)
    item_count < CNT_W'(MAX_ITEMS))
    else $error("item count reached the store size");

  // While emitting, at least one result remains owed.
  a_need_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (need != '0))
    else $error("emitting with no results owed");

  // The level pointer goes at most one past the top level.
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ptr <= PTR_W'(NUM_LEVELS))
    else $error("level pointer past the top level");

  // Emitting the final result closes the set and marks it.
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    ctrl.clear |=> (state == ST_LOAD) && out_valid && out_last)
    else $error("final result did not close the set");

  // No item is taken while a set is being emitted.
  a_no_load_in_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> !ctrl.inc)
    else $error("item loaded during emission");

endmodule

`default_nettype wire
